>>> rtl/core/scshf_pkg.sv
// Shared types, constants and helpers for the swept circle segment hit fraction block.
package scshf_pkg;

  localparam int CW       = 32;
  localparam int RW       = CW - 1;
  localparam int DW       = CW + 1;
  localparam int OUT_FRAC = 16;
  localparam int FW       = OUT_FRAC + 1;
  localparam int PW       = 72;
  localparam int W        = 200;
  localparam int SQW      = 128;
  localparam int SQI      = SQW / 2;
  localparam int CNTW     = $clog2(SQI);

  localparam logic [FW-1:0] FRAC_ONE = FW'(1) << OUT_FRAC;

  typedef logic signed [W-1:0]  wide_t;
  typedef logic signed [PW-1:0] pv_t;

  typedef enum logic [1:0] {
    K_ZERO  = 2'd0,
    K_POINT = 2'd1,
    K_PARA  = 2'd2,
    K_GEN   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } ar_req_t;

  typedef struct packed {
    kind_e           kind;
    logic            sw;
    logic            side_neg;
    logic [RW-1:0]   r;
    pv_t             r2;
    pv_t             q;
    pv_t             m;
    pv_t             pd_a;
    pv_t             pd_b;
    pv_t             pc_a;
    pv_t             pc_b;
    pv_t             de;
    pv_t             h;
    pv_t             sd;
  } item_t;

  function automatic wide_t wx(pv_t v);
    return {{(W-PW){v[PW-1]}}, v};
  endfunction

  function automatic logic signed [1:0] sgn(wide_t v);
    if (v[W-1]) return -2'sd1;
    if (v == '0) return 2'sd0;
    return 2'sd1;
  endfunction

  function automatic logic signed [1:0] cmp_root(wide_t y, wide_t x, wide_t yym, wide_t xx);
    logic signed [1:0] sy;
    logic signed [1:0] sx;
    logic signed [1:0] d;
    sy = sgn(y);
    sx = sgn(x);
    if (yym < xx) d = -2'sd1;
    else if (yym == xx) d = 2'sd0;
    else d = 2'sd1;
    if (sy != sx) return (sy > sx) ? 2'sd1 : -2'sd1;
    if (sy == 2'sd0) return 2'sd0;
    return (sy > 2'sd0) ? d : -d;
  endfunction

endpackage

>>> rtl/core/swept_circle_segment_hit_fraction.sv
// Top level of the swept circle against segment hit fraction block.
// Each input word is one independent query: a circle of the given radius at a centre, moving by
// a vector, against one segment; coordinates are signed Q16.16, the radius unsigned Q15.16. The
// result word gives the fraction of the move done before first contact in Q1.16 (65536 when
// there is no contact) and a hit flag. A three-stage front pipeline takes one word per cycle
// while the queue has room, forms all coordinate products and classifies the query into a
// two-entry queue. The back part solves each query on one shared serial unit that does a
// shift-add multiply (one multiplier bit per cycle), a square root (two radicand bits per cycle)
// and the final divide. That unit sets the rate of results: the time taken by one query depends
// on its case and on operand magnitudes, and the next query waits in the queue. The output
// register lets the front keep taking words while a result waits.
module swept_circle_segment_hit_fraction (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [scshf_pkg::RW-1:0]        radius_i,
  input  logic signed [scshf_pkg::CW-1:0] center_x_i,
  input  logic signed [scshf_pkg::CW-1:0] center_y_i,
  input  logic signed [scshf_pkg::CW-1:0] move_x_i,
  input  logic signed [scshf_pkg::CW-1:0] move_y_i,
  input  logic signed [scshf_pkg::CW-1:0] seg_a_x_i,
  input  logic signed [scshf_pkg::CW-1:0] seg_a_y_i,
  input  logic signed [scshf_pkg::CW-1:0] seg_b_x_i,
  input  logic signed [scshf_pkg::CW-1:0] seg_b_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [scshf_pkg::FW-1:0]        hit_fraction_o,
  output logic                            hit_o
);
  import scshf_pkg::*;

  logic  push, full, pop, empty;
  item_t f_item, q_item;

  scshf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .radius_i   (radius_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .move_x_i   (move_x_i),
    .move_y_i   (move_y_i),
    .seg_a_x_i  (seg_a_x_i),
    .seg_a_y_i  (seg_a_y_i),
    .seg_b_x_i  (seg_b_x_i),
    .seg_b_y_i  (seg_b_y_i),
    .push_o     (push),
    .item_o     (f_item),
    .full_i     (full)
  );

  scshf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_item)
  );

  scshf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (empty),
    .q_data_i       (q_item),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_fraction_o (hit_fraction_o),
    .hit_o          (hit_o)
  );

endmodule

>>> rtl/core/scshf_front.sv
// Front pipeline: takes query words, forms products and classifies the query.
module scshf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [scshf_pkg::RW-1:0]        radius_i,
  input  logic signed [scshf_pkg::CW-1:0] center_x_i,
  input  logic signed [scshf_pkg::CW-1:0] center_y_i,
  input  logic signed [scshf_pkg::CW-1:0] move_x_i,
  input  logic signed [scshf_pkg::CW-1:0] move_y_i,
  input  logic signed [scshf_pkg::CW-1:0] seg_a_x_i,
  input  logic signed [scshf_pkg::CW-1:0] seg_a_y_i,
  input  logic signed [scshf_pkg::CW-1:0] seg_b_x_i,
  input  logic signed [scshf_pkg::CW-1:0] seg_b_y_i,
  output logic                            push_o,
  output scshf_pkg::item_t                item_o,
  input  logic                            full_i
);
  import scshf_pkg::*;

  logic en;
  logic v1_q, v2_q, v3_q;

  logic [RW-1:0]        r1_q, r2s_q, r3_q;
  logic signed [CW-1:0] dx_q, dy_q;
  logic signed [DW-1:0] vxa_q, vya_q, vxb_q, vyb_q, ex_q, ey_q;

  pv_t pxa_dx_q, pya_dy_q, pya_dx_q, pxa_dy_q;
  pv_t pxb_dx_q, pyb_dy_q, pyb_dx_q, pxb_dy_q;
  pv_t dx2_q, dy2_q, ex2_q, ey2_q, rr_q, w1_q, w2_q;
  logic ez2_q, ez3_q;

  pv_t q3_q, m3_q, pd_a_q, pd_b_q, pc_a_q, pc_b_q, w3_q, rr3_q;

  pv_t cde, ncde, de, nw;
  logic sw;

  assign en         = !(v3_q && full_i);
  assign in_stall_o = !en;
  assign push_o     = v3_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q  <= radius_i;
      dx_q  <= move_x_i;
      dy_q  <= move_y_i;
      vxa_q <= DW'(seg_a_x_i) - DW'(center_x_i);
      vya_q <= DW'(seg_a_y_i) - DW'(center_y_i);
      vxb_q <= DW'(seg_b_x_i) - DW'(center_x_i);
      vyb_q <= DW'(seg_b_y_i) - DW'(center_y_i);
      ex_q  <= DW'(seg_b_x_i) - DW'(seg_a_x_i);
      ey_q  <= DW'(seg_b_y_i) - DW'(seg_a_y_i);

      pxa_dx_q <= PW'(vxa_q) * PW'(dx_q);
      pya_dy_q <= PW'(vya_q) * PW'(dy_q);
      pya_dx_q <= PW'(vya_q) * PW'(dx_q);
      pxa_dy_q <= PW'(vxa_q) * PW'(dy_q);
      pxb_dx_q <= PW'(vxb_q) * PW'(dx_q);
      pyb_dy_q <= PW'(vyb_q) * PW'(dy_q);
      pyb_dx_q <= PW'(vyb_q) * PW'(dx_q);
      pxb_dy_q <= PW'(vxb_q) * PW'(dy_q);
      dx2_q    <= PW'(dx_q) * PW'(dx_q);
      dy2_q    <= PW'(dy_q) * PW'(dy_q);
      ex2_q    <= PW'(ex_q) * PW'(ex_q);
      ey2_q    <= PW'(ey_q) * PW'(ey_q);
      rr_q     <= PW'({1'b0, r1_q}) * PW'({1'b0, r1_q});
      w1_q     <= PW'(ex_q) * PW'(vya_q);
      w2_q     <= PW'(ey_q) * PW'(vxa_q);
      ez2_q    <= (ex_q == '0) && (ey_q == '0);
      r2s_q    <= r1_q;

      q3_q   <= dx2_q + dy2_q;
      m3_q   <= ex2_q + ey2_q;
      pd_a_q <= pxa_dx_q + pya_dy_q;
      pc_a_q <= pya_dx_q - pxa_dy_q;
      pd_b_q <= pxb_dx_q + pyb_dy_q;
      pc_b_q <= pyb_dx_q - pxb_dy_q;
      w3_q   <= w1_q - w2_q;
      rr3_q  <= rr_q;
      ez3_q  <= ez2_q;
      r3_q   <= r2s_q;
    end
  end

  always_comb begin
    cde  = pc_a_q - pc_b_q;
    ncde = pc_b_q - pc_a_q;
    de   = pd_b_q - pd_a_q;
    nw   = -w3_q;
    sw   = cde[PW-1];

    item_o.sw       = sw;
    item_o.side_neg = (r3_q != '0) && w3_q[PW-1];
    item_o.r        = r3_q;
    item_o.r2       = rr3_q;
    item_o.q        = q3_q;
    item_o.m        = m3_q;
    item_o.pd_a     = pd_a_q;
    item_o.pd_b     = pd_b_q;
    item_o.pc_a     = pc_a_q;
    item_o.pc_b     = pc_b_q;
    item_o.de       = de;
    item_o.h        = sw ? ncde : cde;
    item_o.sd       = sw ? nw : w3_q;

    if (q3_q == '0) item_o.kind = K_ZERO;
    else if (ez3_q) item_o.kind = K_POINT;
    else if (cde == '0) item_o.kind = K_PARA;
    else item_o.kind = K_GEN;
  end

endmodule

>>> rtl/core/scshf_fifo.sv
// Two-entry queue of classified queries between the front and back parts.
module scshf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  scshf_pkg::item_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output scshf_pkg::item_t data_o
);
  import scshf_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign data_o  = mem_q[rp_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule

>>> rtl/core/scshf_arith.sv
// Shared serial unit: shift-add multiply, rounded-up square root, fraction divide.
module scshf_arith (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scshf_pkg::ar_req_t req_i,
  input  scshf_pkg::wide_t   a_i,
  input  scshf_pkg::wide_t   b_i,
  output logic               done_o,
  output scshf_pkg::wide_t   res_o
);
  import scshf_pkg::*;

  logic busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  op_e  op_q, op_d;
  wide_t x_q, x_d, y_q, y_d, acc_q, acc_d, res_q, res_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  wide_t rem2, trial, rem_n, root_n, sub;
  logic  ge_s, ge_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    op_d   = op_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    res_d  = res_q;
    cnt_d  = cnt_q;

    rem2   = {acc_q[W-3:0], x_q[SQW-1:SQW-2]};
    trial  = {y_q[W-3:0], 2'b01};
    ge_s   = rem2 >= trial;
    rem_n  = ge_s ? rem2 - trial : rem2;
    root_n = {y_q[W-2:0], ge_s};
    ge_d   = x_q >= y_q;
    sub    = ge_d ? x_q - y_q : x_q;

    if (!busy_q) begin
      if (req_i.start) begin
        op_d = req_i.op;
        case (req_i.op)
          OP_MUL: begin
            busy_d = 1'b1;
            neg_d  = a_i[W-1] ^ b_i[W-1];
            x_d    = a_i[W-1] ? -a_i : a_i;
            y_d    = b_i[W-1] ? -b_i : b_i;
            acc_d  = '0;
          end
          OP_SQRT: begin
            if (a_i[W-1] || (a_i == '0)) begin
              done_d = 1'b1;
              res_d  = '0;
            end else begin
              busy_d = 1'b1;
              x_d    = a_i;
              y_d    = '0;
              acc_d  = '0;
              cnt_d  = CNTW'(SQI - 1);
            end
          end
          OP_DIV: begin
            if (a_i[W-1]) begin
              done_d = 1'b1;
              res_d  = '0;
            end else if (a_i > b_i) begin
              done_d = 1'b1;
              res_d  = {{(W-FW){1'b0}}, FRAC_ONE};
            end else begin
              busy_d = 1'b1;
              x_d    = a_i;
              y_d    = b_i;
              acc_d  = '0;
              cnt_d  = CNTW'(OUT_FRAC);
            end
          end
          default: ;
        endcase
      end
    end else begin
      case (op_q)
        OP_MUL: begin
          if (y_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            res_d  = neg_q ? -acc_q : acc_q;
          end else begin
            acc_d = acc_q + (y_q[0] ? x_q : '0);
            x_d   = x_q << 1;
            y_d   = y_q >> 1;
          end
        end
        OP_SQRT: begin
          acc_d = rem_n;
          y_d   = root_n;
          x_d   = x_q << 2;
          cnt_d = cnt_q - CNTW'(1);
          if (cnt_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            res_d  = root_n + {{(W-1){1'b0}}, (rem_n != '0)};
          end
        end
        OP_DIV: begin
          acc_d = {acc_q[W-2:0], ge_d};
          x_d   = sub << 1;
          cnt_d = cnt_q - CNTW'(1);
          if (cnt_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            res_d  = {acc_q[W-2:0], ge_d};
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    op_q  <= op_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    res_q <= res_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/core/scshf_back.sv
// Back sequencer: resolves side and end contacts on the shared serial unit.
module scshf_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  scshf_pkg::item_t        q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [scshf_pkg::FW-1:0] hit_fraction_o,
  output logic                    hit_o
);
  import scshf_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_OUT   = 16'h0002,
    ET_R2Q   = 16'h0004,
    ET_PC2   = 16'h0008,
    ET_PD2   = 16'h0010,
    ET_SQRT  = 16'h0020,
    ET_DIV   = 16'h0040,
    G_OFF    = 16'h0080,
    G_OFF2   = 16'h0100,
    G_Y2SQ   = 16'h0200,
    G_Y2M    = 16'h0400,
    G_Y1SQ   = 16'h0800,
    G_Y1M    = 16'h1000,
    G_R2M    = 16'h2000,
    G_SQRT   = 16'h4000,
    G_DIV    = 16'h8000
  } st_e;

  typedef enum logic [1:0] {
    RET_OUT = 2'd0,
    RET_PA  = 2'd1,
    RET_PB  = 2'd2
  } ret_e;

  st_e   st_q, st_d;
  logic  pend_q, pend_d;
  item_t it_q, it_d;
  ret_e  ret_q, ret_d;
  logic  sel_b_q, sel_b_d;
  logic [FW-1:0] fa_q, fa_d, f_q, f_d;
  wide_t t0_q, t0_d, t1_q, t1_d, off_q, off_d, off2_q, off2_d;
  logic  oval_q, oval_d;
  logic [FW-1:0] ofrac_q, ofrac_d;

  ar_req_t ar_req;
  wide_t   ar_a, ar_b, ar_res;
  logic    ar_done, go;

  wide_t et_pd, et_pc, y2, y1, g, wr;
  logic  et_fin, out_load;
  logic [FW-1:0] et_f;

  scshf_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ar_req),
    .a_i    (ar_a),
    .b_i    (ar_b),
    .done_o (ar_done),
    .res_o  (ar_res)
  );

  assign go = pend_q && ar_done;

  always_comb begin
    st_d     = st_q;
    pend_d   = pend_q;
    it_d     = it_q;
    ret_d    = ret_q;
    sel_b_d  = sel_b_q;
    fa_d     = fa_q;
    f_d      = f_q;
    t0_d     = t0_q;
    t1_d     = t1_q;
    off_d    = off_q;
    off2_d   = off2_q;
    ar_req.start = 1'b0;
    ar_req.op    = OP_MUL;
    ar_a     = '0;
    ar_b     = '0;
    q_pop_o  = 1'b0;
    et_fin   = 1'b0;
    et_f     = FRAC_ONE;
    out_load = 1'b0;

    et_pd = sel_b_q ? wx(it_q.pd_b) : wx(it_q.pd_a);
    et_pc = sel_b_q ? wx(it_q.pc_b) : wx(it_q.pc_a);
    y2    = it_q.sw ? wx(it_q.pc_a) : wx(it_q.pc_b);
    y1    = it_q.sw ? wx(it_q.pc_b) : wx(it_q.pc_a);
    g     = t0_q - ar_res;
    wr    = {{(W-RW){1'b0}}, it_q.r};

    if ((st_q != ST_IDLE) && (st_q != ST_OUT) && !pend_q) begin
      ar_req.start = 1'b1;
      pend_d       = 1'b1;
    end
    if (go) pend_d = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          it_d    = q_data_i;
          case (q_data_i.kind)
            K_ZERO: begin
              f_d  = FRAC_ONE;
              st_d = ST_OUT;
            end
            K_POINT: begin
              sel_b_d = 1'b1;
              ret_d   = RET_OUT;
              st_d    = ET_R2Q;
            end
            K_PARA: begin
              sel_b_d = 1'b0;
              ret_d   = RET_PA;
              st_d    = ET_R2Q;
            end
            default: st_d = G_OFF;
          endcase
        end
      end
      ST_OUT: begin
        if (!oval_q || !out_stall_i) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      ET_R2Q: begin
        ar_a = wx(it_q.q);
        ar_b = wx(it_q.r2);
        if (go) begin
          t0_d = ar_res;
          st_d = ET_PC2;
        end
      end
      ET_PC2: begin
        ar_a = et_pc;
        ar_b = et_pc;
        if (go) begin
          t0_d = g;
          if (g[W-1] || et_pd[W-1]) begin
            et_fin = 1'b1;
            et_f   = FRAC_ONE;
          end else begin
            st_d = ET_PD2;
          end
        end
      end
      ET_PD2: begin
        ar_a = et_pd;
        ar_b = et_pd;
        if (go) begin
          if (ar_res < t0_q) begin
            et_fin = 1'b1;
            et_f   = '0;
          end else begin
            st_d = ET_SQRT;
          end
        end
      end
      ET_SQRT: begin
        ar_req.op = OP_SQRT;
        ar_a      = t0_q;
        if (go) begin
          t1_d = ar_res;
          st_d = ET_DIV;
        end
      end
      ET_DIV: begin
        ar_req.op = OP_DIV;
        ar_a      = et_pd - t1_q;
        ar_b      = wx(it_q.q);
        if (go) begin
          et_fin = 1'b1;
          et_f   = ar_res[FW-1:0];
        end
      end
      G_OFF: begin
        ar_a = wx(it_q.de);
        ar_b = wr;
        if (go) begin
          off_d = it_q.side_neg ? -ar_res : ar_res;
          st_d  = G_OFF2;
        end
      end
      G_OFF2: begin
        ar_a = off_q;
        ar_b = off_q;
        if (go) begin
          off2_d = ar_res;
          st_d   = G_Y2SQ;
        end
      end
      G_Y2SQ: begin
        ar_a = y2;
        ar_b = y2;
        if (go) begin
          t0_d = ar_res;
          st_d = G_Y2M;
        end
      end
      G_Y2M: begin
        ar_a = t0_q;
        ar_b = wx(it_q.m);
        if (go) begin
          if (cmp_root(y2, off_q, ar_res, off2_q) == 2'sd1) begin
            sel_b_d = !it_q.sw;
            ret_d   = RET_OUT;
            st_d    = ET_R2Q;
          end else begin
            st_d = G_Y1SQ;
          end
        end
      end
      G_Y1SQ: begin
        ar_a = y1;
        ar_b = y1;
        if (go) begin
          t0_d = ar_res;
          st_d = G_Y1M;
        end
      end
      G_Y1M: begin
        ar_a = t0_q;
        ar_b = wx(it_q.m);
        if (go) begin
          if (cmp_root(y1, off_q, ar_res, off2_q) == -2'sd1) begin
            sel_b_d = it_q.sw;
            ret_d   = RET_OUT;
            st_d    = ET_R2Q;
          end else begin
            st_d = G_R2M;
          end
        end
      end
      G_R2M: begin
        ar_a = wx(it_q.m);
        ar_b = wx(it_q.r2);
        if (go) begin
          t0_d = ar_res;
          st_d = G_SQRT;
        end
      end
      G_SQRT: begin
        ar_req.op = OP_SQRT;
        ar_a      = t0_q;
        if (go) begin
          t1_d = ar_res;
          st_d = G_DIV;
        end
      end
      G_DIV: begin
        ar_req.op = OP_DIV;
        ar_a      = wx(it_q.sd) - t1_q;
        ar_b      = wx(it_q.h);
        if (go) begin
          f_d  = ar_res[FW-1:0];
          st_d = ST_OUT;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (et_fin) begin
      case (ret_q)
        RET_PA: begin
          fa_d    = et_f;
          sel_b_d = 1'b1;
          ret_d   = RET_PB;
          st_d    = ET_R2Q;
        end
        RET_PB: begin
          f_d  = (et_f < fa_q) ? et_f : fa_q;
          st_d = ST_OUT;
        end
        default: begin
          f_d  = et_f;
          st_d = ST_OUT;
        end
      endcase
    end

    oval_d  = out_load | (oval_q & out_stall_i);
    ofrac_d = out_load ? f_q : ofrac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      pend_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pend_q <= pend_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    ret_q   <= ret_d;
    sel_b_q <= sel_b_d;
    fa_q    <= fa_d;
    f_q     <= f_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    off_q   <= off_d;
    off2_q  <= off2_d;
    ofrac_q <= ofrac_d;
  end

  assign out_valid_o    = oval_q;
  assign hit_fraction_o = ofrac_q;
  assign hit_o          = ofrac_q < FRAC_ONE;

endmodule
